>>> rtl/log_batch_flush_controller_macros.svh
// assertion macros shared by the flush controller rtl
`ifndef LOG_BATCH_FLUSH_CONTROLLER_MACROS_SVH
`define LOG_BATCH_FLUSH_CONTROLLER_MACROS_SVH

// property that must hold on every clock edge outside reset
`define LBFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// same-cycle implication outside reset
`define LBFC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication outside reset
`define LBFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lbfc_pkg.sv
// types and constants of the log batch flush controller
package lbfc_pkg;

  localparam int CNT_W  = 23;
  localparam int TIME_W = 32;
  localparam int SEC_W  = 16;

  // buffer size in bytes, count saturates here
  localparam int unsigned BUFFER_BYTES = 4194304;
  localparam logic [CNT_W-1:0] BUF_BYTES = CNT_W'(BUFFER_BYTES);

  // register reset values
  localparam logic [CNT_W-1:0] THRESHOLD_RST = CNT_W'(1048576);
  localparam logic [SEC_W-1:0] COLLECT_RST   = SEC_W'(60);
  localparam logic [SEC_W-1:0] TIMEOUT_RST   = SEC_W'(120);
  localparam logic [SEC_W-1:0] COOLDOWN_RST  = SEC_W'(30);

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_COLLECT = 2'd1,
    ST_FLIGHT  = 2'd2,
    ST_COOL    = 2'd3
  } state_e;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_BYTES = 2'd1,
    OP_PUSH  = 2'd2,
    OP_DONE  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    TM_KEEP   = 2'd0,
    TM_ARM    = 2'd1,
    TM_DISARM = 2'd2
  } timer_e;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_COLLECT   = 2'd1,
    REG_TIMEOUT   = 2'd2,
    REG_COOLDOWN  = 2'd3
  } cfg_reg_e;

endpackage

>>> rtl/log_batch_flush_controller.sv
// log batch flush controller: byte counting, flush trigger and timeout state machine
//
// Usage: one event word enters on the in channel (opcode, now_seconds_i and the
// opcode's own fields) and exactly one result word leaves on the out channel.
// Words are taken when valid is high and stall is low; the receiver drives stall.
// Configuration registers (threshold, collect, timeout, cooldown) are written
// through the cfg channel; cfg_ready_o is always high. The user must write them only
// while no event is in the block; the block itself does not enforce this.
// An accepted word passes through the input register and then the result register.
// Throughput: one word per cycle while out_stall_i is low. The whole state chain
// of an event (flight timeout, cooldown expiry, collect and flush start) settles
// in the single logic stage between the input register and the result register.
// Stall: while out_stall_i holds a result, the input register keeps its word and
// in_stall_o rises only once that register is also full, so one word is buffered.
// Reset: state idle, byte count, marks and pending push cleared, registers to
// their default values, both valid flags low.
module log_batch_flush_controller (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // event channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  opcode_i,
  input  logic [lbfc_pkg::TIME_W-1:0] now_seconds_i,
  input  logic [lbfc_pkg::CNT_W-1:0]  added_bytes_i,
  input  logic                        has_newline_i,
  input  logic                        flush_ok_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        flush_start_o,
  output logic [lbfc_pkg::CNT_W-1:0]  flush_size_o,
  output logic                        flush_abort_o,
  output logic [1:0]                  timer_action_o,
  output logic [lbfc_pkg::TIME_W-1:0] timer_deadline_o,
  output logic [1:0]                  state_code_o,
  output logic [lbfc_pkg::CNT_W-1:0]  free_bytes_o,
  output logic                        done_pulse_o,
  // configuration channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [lbfc_pkg::CNT_W-1:0]  cfg_data_i
);

  `include "log_batch_flush_controller_macros.svh"

  localparam int CW = lbfc_pkg::CNT_W;
  localparam int TW = lbfc_pkg::TIME_W;
  localparam int SW = lbfc_pkg::SEC_W;

  // configuration registers
  logic [CW-1:0] thr_q;
  logic [SW-1:0] collect_q, timeout_q, cooldown_q;

  // input register
  logic                in_valid_q;
  lbfc_pkg::opcode_e   op_q;
  logic [TW-1:0]       now_q;
  logic [CW-1:0]       added_q;
  logic                nl_q, ok_q;

  // controller state
  lbfc_pkg::state_e    mode_q, mode_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [TW-1:0]       mark_q, mark_d;
  logic [CW-1:0]       infl_q, infl_d;
  logic                pp_q, pp_d;

  // result register
  logic                out_valid_q;
  logic                start_q, start_d;
  logic [CW-1:0]       size_q, size_d;
  logic                abort_q, abort_d;
  lbfc_pkg::timer_e    tact_q, tact_d;
  logic [TW-1:0]       tdead_q, tdead_d;
  lbfc_pkg::state_e    st_out_q;
  logic [CW-1:0]       free_q, free_d;
  logic                done_q, done_d;

  // handshake
  logic adv, fire, in_acc;

  assign adv        = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && adv;
  assign in_stall_o = in_valid_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= lbfc_pkg::THRESHOLD_RST;
      collect_q  <= lbfc_pkg::COLLECT_RST;
      timeout_q  <= lbfc_pkg::TIMEOUT_RST;
      cooldown_q <= lbfc_pkg::COOLDOWN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (lbfc_pkg::cfg_reg_e'(cfg_index_i))
        lbfc_pkg::REG_THRESHOLD: thr_q      <= cfg_data_i;
        lbfc_pkg::REG_COLLECT:   collect_q  <= cfg_data_i[SW-1:0];
        lbfc_pkg::REG_TIMEOUT:   timeout_q  <= cfg_data_i[SW-1:0];
        lbfc_pkg::REG_COOLDOWN:  cooldown_q <= cfg_data_i[SW-1:0];
        default: ;
      endcase
    end
  end

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_acc) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= lbfc_pkg::opcode_e'(opcode_i);
      now_q   <= now_seconds_i;
      added_q <= added_bytes_i;
      nl_q    <= has_newline_i;
      ok_q    <= flush_ok_i;
    end
  end

  // deadline sums, compared at full width
  logic [TW:0] now_w, fl_end, cd_end, cl_end, now_ft, now_cs;
  logic [CW:0] add_sum;

  assign now_w   = {1'b0, now_q};
  assign fl_end  = {1'b0, mark_q} + (TW+1)'(timeout_q);
  assign cd_end  = {1'b0, mark_q} + (TW+1)'(cooldown_q);
  assign cl_end  = {1'b0, mark_q} + (TW+1)'(collect_q);
  assign now_ft  = now_w + (TW+1)'(timeout_q);
  assign now_cs  = now_w + (TW+1)'(collect_q);
  assign add_sum = {1'b0, cnt_q} + {1'b0, added_q};

  // event handling and state chain
  logic ev, go_collect, from_idle, cool_step, expired;

  always_comb begin
    mode_d  = mode_q;
    cnt_d   = cnt_q;
    mark_d  = mark_q;
    infl_d  = infl_q;
    pp_d    = pp_q;
    ev      = 1'b0;
    done_d  = 1'b0;
    start_d = 1'b0;
    size_d  = '0;
    abort_d = 1'b0;
    tact_d  = lbfc_pkg::TM_KEEP;
    tdead_d = '0;
    go_collect = 1'b0;
    from_idle  = 1'b0;
    cool_step  = 1'b0;
    expired    = 1'b0;

    // opcode pre-processing
    unique case (op_q)
      lbfc_pkg::OP_TICK: ev = 1'b1;
      lbfc_pkg::OP_BYTES: begin
        if (add_sum > {1'b0, lbfc_pkg::BUF_BYTES}) begin
          cnt_d = lbfc_pkg::BUF_BYTES;
        end else begin
          cnt_d = add_sum[CW-1:0];
        end
        ev = nl_q;
      end
      lbfc_pkg::OP_PUSH: begin
        pp_d = 1'b1;
        ev   = 1'b1;
      end
      lbfc_pkg::OP_DONE: begin
        if (ok_q) begin
          cnt_d = (infl_q <= cnt_q) ? (cnt_q - infl_q) : '0;
        end
        pp_d   = 1'b0;
        infl_d = '0;
        mode_d = lbfc_pkg::ST_COOL;
        ev     = 1'b1;
        done_d = 1'b1;
      end
      default: ;
    endcase

    // first state of the chain
    if (ev) begin
      unique case (mode_d)
        lbfc_pkg::ST_IDLE: begin
          if (cnt_d != '0) begin
            go_collect = 1'b1;
            from_idle  = 1'b1;
          end
        end
        lbfc_pkg::ST_COLLECT: go_collect = 1'b1;
        lbfc_pkg::ST_FLIGHT: begin
          if (fl_end <= now_w) begin
            abort_d   = 1'b1;
            infl_d    = '0;
            tact_d    = lbfc_pkg::TM_DISARM;
            tdead_d   = '0;
            mode_d    = lbfc_pkg::ST_COOL;
            cool_step = 1'b1;
          end
        end
        lbfc_pkg::ST_COOL: cool_step = 1'b1;
        default: ;
      endcase
    end

    // cooldown check
    if (cool_step) begin
      if (now_w < cd_end) begin
        tact_d  = lbfc_pkg::TM_ARM;
        tdead_d = cd_end[TW-1:0];
      end else if (cnt_d != '0) begin
        go_collect = 1'b1;
      end else begin
        mode_d = lbfc_pkg::ST_IDLE;
      end
    end

    // collecting: start a flush or arm the collect deadline
    if (go_collect) begin
      mode_d  = lbfc_pkg::ST_COLLECT;
      expired = from_idle ? (collect_q == '0) : (now_w >= cl_end);
      if (from_idle) begin
        mark_d = now_q;
      end
      if (pp_d || (cnt_d >= thr_q) || expired) begin
        start_d = 1'b1;
        size_d  = cnt_d;
        infl_d  = cnt_d;
        mark_d  = now_q;
        tact_d  = lbfc_pkg::TM_ARM;
        tdead_d = now_ft[TW-1:0];
        mode_d  = lbfc_pkg::ST_FLIGHT;
      end else begin
        tact_d  = lbfc_pkg::TM_ARM;
        tdead_d = from_idle ? now_cs[TW-1:0] : cl_end[TW-1:0];
      end
    end

    free_d = lbfc_pkg::BUF_BYTES - cnt_d;
  end

  // controller state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= lbfc_pkg::ST_IDLE;
      cnt_q  <= '0;
      mark_q <= '0;
      infl_q <= '0;
      pp_q   <= 1'b0;
    end else if (fire) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      mark_q <= mark_d;
      infl_q <= infl_d;
      pp_q   <= pp_d;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      start_q  <= start_d;
      size_q   <= size_d;
      abort_q  <= abort_d;
      tact_q   <= tact_d;
      tdead_q  <= tdead_d;
      st_out_q <= mode_d;
      free_q   <= free_d;
      done_q   <= done_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign flush_start_o    = start_q;
  assign flush_size_o     = size_q;
  assign flush_abort_o    = abort_q;
  assign timer_action_o   = tact_q;
  assign timer_deadline_o = tdead_q;
  assign state_code_o     = st_out_q;
  assign free_bytes_o     = free_q;
  assign done_pulse_o     = done_q;

  // checks
  `LBFC_ASSERT(cnt_bounded_a, cnt_q <= lbfc_pkg::BUF_BYTES, "byte count above buffer size")
  `LBFC_ASSERT_IMP(start_in_flight_a, out_valid_q && start_q,
      st_out_q == lbfc_pkg::ST_FLIGHT, "flush started without entering flight")
  `LBFC_ASSERT_IMP(abort_sets_timer_a, out_valid_q && abort_q,
      tact_q != lbfc_pkg::TM_KEEP, "abort left the timer untouched")
  `LBFC_ASSERT_NEXT(fire_gives_result_a, fire, out_valid_q, "processed word produced no result")

endmodule
